>>> rtl/printf_integer_formatter_core_assert.svh
// assertion macros shared by the formatter checker
`ifndef PRINTF_INTEGER_FORMATTER_CORE_ASSERT_SVH
`define PRINTF_INTEGER_FORMATTER_CORE_ASSERT_SVH

// same-cycle implication under the asynchronous reset
`define PIFC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("formatter assertion failed");

// next-cycle implication under the asynchronous reset
`define PIFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("formatter assertion failed");

`endif

>>> rtl/pifc_pkg.sv
// shared constants, types and helpers of the integer formatter
`timescale 1ns / 1ps
package pifc_pkg;

	localparam int MAX_OUT = 64;
	localparam int DIG_N   = 22;
	localparam int DIG_W   = 4 * DIG_N;

	localparam logic [1:0] SIZE_INT   = 2'd0;
	localparam logic [1:0] SIZE_CHAR  = 2'd1;
	localparam logic [1:0] SIZE_SHORT = 2'd2;
	localparam logic [1:0] SIZE_LONG  = 2'd3;

	localparam logic [1:0] BASE_OCT = 2'd0;
	localparam logic [1:0] BASE_DEC = 2'd1;
	localparam logic [1:0] BASE_HEX = 2'd2;

	localparam int FLG_ALT   = 0;
	localparam int FLG_PLUS  = 1;
	localparam int FLG_SPACE = 2;
	localparam int FLG_ZERO  = 3;
	localparam int FLG_LEFT  = 4;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_X     = 8'h78;

	// one formatted number, ready for character output
	typedef struct packed {
		logic [DIG_W-1:0] digits;  // most significant digit at the top
		logic [4:0]       nd;
		logic [6:0]       lead;
		logic [1:0]       plen;
		logic [7:0]       pfx0;
		logic [7:0]       pfx1;
		logic [6:0]       zeros;
		logic [6:0]       total;
	} job_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		logic [7:0] c;
		if (d < 4'd10) begin
			c = CH_ZERO + {4'b0, d};
		end else begin
			c = CH_A + {4'b0, d} - 8'd10;
		end
		return c;
	endfunction

endpackage

>>> rtl/pifc_in_if.sv
// channel carrying one integer argument with its conversion spec
`timescale 1ns / 1ps
interface pifc_in_if;
	logic              valid;
	logic              ready;
	logic [63:0]       value;
	logic [1:0]        size_mode;
	logic              is_unsigned;
	logic [1:0]        base_sel;
	logic [4:0]        format_flags;
	logic [6:0]        field_width;
	logic signed [6:0] precision;

	modport source (
		output valid, value, size_mode, is_unsigned, base_sel, format_flags,
			field_width, precision,
		input  ready
	);
	modport sink (
		input  valid, value, size_mode, is_unsigned, base_sel, format_flags,
			field_width, precision,
		output ready
	);
endinterface

>>> rtl/pifc_out_if.sv
// channel carrying one output character with its last marker
`timescale 1ns / 1ps
interface pifc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last_char;

	modport source (output valid, character, last_char, input ready);
	modport sink (input valid, character, last_char, output ready);
endinterface

>>> rtl/pifc_front.sv
// front end: takes an argument, converts it to digits and lays out the text
`timescale 1ns / 1ps
module pifc_front (
	input  logic           clk,
	input  logic           arst_n,
	pifc_in_if.sink        arg,
	output pifc_pkg::job_t job,
	output logic           job_valid,
	input  logic           job_ready
);
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CONV   = 3'd1;
	localparam logic [2:0] ST_DABBLE = 3'd2;
	localparam logic [2:0] ST_NORM   = 3'd3;
	localparam logic [2:0] ST_LAYOUT = 3'd4;

	localparam int DW = pifc_pkg::DIG_W;

	logic [2:0]    state_q;
	logic [63:0]   mag_q;
	logic [63:0]   sh_q;
	logic [DW-1:0] dig_q;
	logic [4:0]    nd_q;
	logic [6:0]    cnt_q;
	logic [1:0]    size_q;
	logic [1:0]    base_q;
	logic          sdec_q;
	logic          neg_q;
	logic [4:0]    flags_q;
	logic [6:0]    width_q;
	logic          prec_none_q;
	logic [5:0]    prec_q;

	logic [63:0]   mask_c;
	logic          sign_c;
	logic          sdec_c;
	logic          neg_c;
	logic [63:0]   masked_c;
	logic [63:0]   mag_c;
	logic [6:0]    width_c;
	logic [5:0]    prec_c;
	logic [63:0]   align_c;
	logic [6:0]    bits_c;
	logic [65:0]   oct_src_c;
	logic [DW-1:0] oct_c;
	logic [DW-1:0] hex_c;
	logic [DW-1:0] adj_c;
	logic          norm_done_c;

	// argument reduction at acceptance
	always_comb begin
		unique case (arg.size_mode)
			pifc_pkg::SIZE_INT: begin
				mask_c = 64'h0000_0000_ffff_ffff;
				sign_c = arg.value[31];
			end
			pifc_pkg::SIZE_CHAR: begin
				mask_c = 64'h0000_0000_0000_00ff;
				sign_c = arg.value[7];
			end
			pifc_pkg::SIZE_SHORT: begin
				mask_c = 64'h0000_0000_0000_ffff;
				sign_c = arg.value[15];
			end
			default: begin
				mask_c = '1;
				sign_c = arg.value[63];
			end
		endcase
		sdec_c   = (arg.base_sel == pifc_pkg::BASE_DEC) && !arg.is_unsigned;
		neg_c    = sdec_c && sign_c;
		masked_c = arg.value & mask_c;
		mag_c    = neg_c ? ((~masked_c + 64'd1) & mask_c) : masked_c;
		width_c  = (int'(arg.field_width) > pifc_pkg::MAX_OUT) ?
			7'(pifc_pkg::MAX_OUT) : arg.field_width;
		prec_c   = (int'(arg.precision[5:0]) > pifc_pkg::MAX_OUT - 2) ?
			6'(pifc_pkg::MAX_OUT - 2) : arg.precision[5:0];
	end

	// digit sources: value left aligned for the decimal shift, direct slices otherwise
	always_comb begin
		unique case (size_q)
			pifc_pkg::SIZE_INT: begin
				align_c = {mag_q[31:0], 32'b0};
				bits_c  = 7'd32;
			end
			pifc_pkg::SIZE_CHAR: begin
				align_c = {mag_q[7:0], 56'b0};
				bits_c  = 7'd8;
			end
			pifc_pkg::SIZE_SHORT: begin
				align_c = {mag_q[15:0], 48'b0};
				bits_c  = 7'd16;
			end
			default: begin
				align_c = mag_q;
				bits_c  = 7'd64;
			end
		endcase
		oct_src_c = {2'b0, mag_q};
		for (int i = 0; i < pifc_pkg::DIG_N; i++) begin
			oct_c[4*i +: 4] = {1'b0, oct_src_c[3*i +: 3]};
		end
		hex_c = {(DW-64)'(0), mag_q};
	end

	// add-three correction of every bcd digit before the shift
	always_comb begin
		for (int i = 0; i < pifc_pkg::DIG_N; i++) begin
			adj_c[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ?
				dig_q[4*i +: 4] + 4'd3 : dig_q[4*i +: 4];
		end
		norm_done_c = (nd_q == 5'd0) || (dig_q[DW-1 -: 4] != 4'd0);
	end

	// text layout of the normalized digits
	logic [6:0] nd7_c;
	logic [6:0] min_dig_c;
	logic [6:0] ndig0_c;
	logic [6:0] ndig_c;
	logic [6:0] body_c;
	logic [6:0] pad_c;
	logic       zpad_c;
	logic       ljust_c;
	logic       alt_c;

	always_comb begin
		alt_c     = flags_q[pifc_pkg::FLG_ALT];
		ljust_c   = flags_q[pifc_pkg::FLG_LEFT];
		zpad_c    = flags_q[pifc_pkg::FLG_ZERO] && prec_none_q && !ljust_c;
		nd7_c     = {2'b0, nd_q};
		min_dig_c = prec_none_q ? 7'd1 : {1'b0, prec_q};
		ndig0_c   = (min_dig_c > nd7_c) ? min_dig_c : nd7_c;
		// octal alternate form needs a leading zero digit
		ndig_c    = (base_q == pifc_pkg::BASE_OCT && alt_c && ndig0_c == nd7_c) ?
			ndig0_c + 7'd1 : ndig0_c;

		job.pfx0 = pifc_pkg::CH_ZERO;
		job.pfx1 = pifc_pkg::CH_X;
		job.plen = 2'd0;
		if (base_q[1] && alt_c && nd_q != 5'd0) begin
			job.plen = 2'd2;
		end else if (sdec_q) begin
			priority if (neg_q) begin
				job.pfx0 = pifc_pkg::CH_MINUS;
				job.plen = 2'd1;
			end else if (flags_q[pifc_pkg::FLG_PLUS]) begin
				job.pfx0 = pifc_pkg::CH_PLUS;
				job.plen = 2'd1;
			end else if (flags_q[pifc_pkg::FLG_SPACE]) begin
				job.pfx0 = pifc_pkg::CH_SPACE;
				job.plen = 2'd1;
			end else begin
				job.plen = 2'd0;
			end
		end

		body_c     = {5'b0, job.plen} + ndig_c;
		pad_c      = (width_q > body_c) ? width_q - body_c : 7'd0;
		job.digits = dig_q;
		job.nd     = nd_q;
		job.lead   = (!ljust_c && !zpad_c) ? pad_c : 7'd0;
		job.zeros  = (zpad_c ? pad_c : 7'd0) + (ndig_c - nd7_c);
		job.total  = body_c + pad_c;
	end

	assign arg.ready = (state_q == ST_IDLE);
	assign job_valid = (state_q == ST_LAYOUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (arg.valid) state_q <= ST_CONV;
				end
				ST_CONV: begin
					state_q <= (base_q == pifc_pkg::BASE_DEC) ? ST_DABBLE : ST_NORM;
				end
				ST_DABBLE: begin
					if (cnt_q == 7'd1) state_q <= ST_NORM;
				end
				ST_NORM: begin
					if (norm_done_c) state_q <= ST_LAYOUT;
				end
				ST_LAYOUT: begin
					if (job_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (arg.valid) begin
					mag_q       <= mag_c;
					size_q      <= arg.size_mode;
					base_q      <= arg.base_sel;
					sdec_q      <= sdec_c;
					neg_q       <= neg_c;
					flags_q     <= arg.format_flags;
					width_q     <= width_c;
					prec_none_q <= arg.precision[6];
					prec_q      <= prec_c;
				end
			end
			ST_CONV: begin
				nd_q <= 5'(pifc_pkg::DIG_N);
				if (base_q == pifc_pkg::BASE_DEC) begin
					sh_q  <= align_c;
					dig_q <= '0;
					cnt_q <= bits_c;
				end else begin
					dig_q <= (base_q == pifc_pkg::BASE_OCT) ? oct_c : hex_c;
				end
			end
			ST_DABBLE: begin
				dig_q <= {adj_c[DW-2:0], sh_q[63]};
				sh_q  <= {sh_q[62:0], 1'b0};
				cnt_q <= cnt_q - 7'd1;
			end
			ST_NORM: begin
				// drop leading zero digits one per cycle
				if (!norm_done_c) begin
					dig_q <= {dig_q[DW-5:0], 4'b0};
					nd_q  <= nd_q - 5'd1;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

>>> rtl/pifc_queue.sv
// two-entry queue of laid-out numbers between front and back
`timescale 1ns / 1ps
module pifc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  pifc_pkg::job_t wr_data,
	input  logic           wr_valid,
	output logic           wr_ready,
	output pifc_pkg::job_t rd_data,
	output logic           rd_valid,
	input  logic           rd_ready
);
	pifc_pkg::job_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign rd_data  = entry_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wr_data;
	end
endmodule

>>> rtl/pifc_emit.sv
// back end: walks a laid-out number and sends one character per transaction
`timescale 1ns / 1ps
module pifc_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  pifc_pkg::job_t job,
	input  logic           job_valid,
	output logic           job_ready,
	pifc_out_if.source     text
);
	localparam int DW = pifc_pkg::DIG_W;

	logic          busy_q;
	logic [6:0]    lead_q;
	logic [1:0]    plen_q;
	logic [7:0]    pfx0_q;
	logic [7:0]    pfx1_q;
	logic [6:0]    zeros_q;
	logic [DW-1:0] dig_q;
	logic [4:0]    nd_q;
	logic [6:0]    rem_q;
	logic          ovalid_q;
	logic [7:0]    char_q;
	logic          last_q;

	logic          advance;
	logic [7:0]    char_c;

	assign job_ready      = !busy_q;
	assign advance        = busy_q && (text.ready || !ovalid_q);
	assign text.valid     = ovalid_q;
	assign text.character = char_q;
	assign text.last_char = last_q;

	// order: leading spaces, prefix, zeros, digits, trailing spaces
	always_comb begin
		priority if (lead_q != 7'd0) begin
			char_c = pifc_pkg::CH_SPACE;
		end else if (plen_q != 2'd0) begin
			char_c = pfx0_q;
		end else if (zeros_q != 7'd0) begin
			char_c = pifc_pkg::CH_ZERO;
		end else if (nd_q != 5'd0) begin
			char_c = pifc_pkg::digit_char(dig_q[DW-1 -: 4]);
		end else begin
			char_c = pifc_pkg::CH_SPACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (text.ready || !ovalid_q) ovalid_q <= advance;
			if (!busy_q) begin
				// an empty number is dropped here
				if (job_valid) busy_q <= (job.total != 7'd0);
			end else if (advance && rem_q == 7'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q) begin
			lead_q  <= job.lead;
			plen_q  <= job.plen;
			pfx0_q  <= job.pfx0;
			pfx1_q  <= job.pfx1;
			zeros_q <= job.zeros;
			dig_q   <= job.digits;
			nd_q    <= job.nd;
			rem_q   <= job.total;
		end else if (advance) begin
			char_q <= char_c;
			last_q <= (rem_q == 7'd1);
			rem_q  <= rem_q - 7'd1;
			priority if (lead_q != 7'd0) begin
				lead_q <= lead_q - 7'd1;
			end else if (plen_q != 2'd0) begin
				pfx0_q <= pfx1_q;
				plen_q <= plen_q - 2'd1;
			end else if (zeros_q != 7'd0) begin
				zeros_q <= zeros_q - 7'd1;
			end else if (nd_q != 5'd0) begin
				dig_q <= {dig_q[DW-5:0], 4'b0};
				nd_q  <= nd_q - 5'd1;
			end else begin
			end
		end
	end
endmodule

>>> rtl/printf_integer_formatter_core.sv
// top level of the printf-style integer formatter
// argument to first character: a decimal argument runs shift-and-add-three over every bit of
// its size mode (8 to 64); then leading zero digits are dropped (up to 22) before layout
// throughput: one character per cycle while the sink is ready; the front holds one argument
// at a time and the back one number at a time, with a two-entry queue between them
// reset clears all control state at once; no clearing pass is needed
`timescale 1ns / 1ps
module printf_integer_formatter_core (
	input  logic       clk,
	input  logic       arst_n,
	pifc_in_if.sink    arg,
	pifc_out_if.source text
);
	pifc_pkg::job_t front_job;
	logic           front_valid;
	logic           front_ready;
	pifc_pkg::job_t back_job;
	logic           back_valid;
	logic           back_ready;

	pifc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.arg       (arg),
		.job       (front_job),
		.job_valid (front_valid),
		.job_ready (front_ready)
	);

	pifc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (front_job),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.rd_data  (back_job),
		.rd_valid (back_valid),
		.rd_ready (back_ready)
	);

	pifc_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (back_job),
		.job_valid (back_valid),
		.job_ready (back_ready),
		.text      (text)
	);
endmodule

>>> rtl/pifc_checker.sv
// port-level checker of the formatter and its bind
`timescale 1ns / 1ps
`include "printf_integer_formatter_core_assert.svh"
module pifc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       text_valid,
	input logic       text_ready,
	input logic [7:0] text_character,
	input logic       text_last_char
);
	`PIFC_ASSERT_NEXT(a_valid_holds, clk, arst_n, text_valid && !text_ready, text_valid)
	`PIFC_ASSERT_NEXT(a_char_holds, clk, arst_n, text_valid && !text_ready, $stable(text_character) && $stable(text_last_char))
	`PIFC_ASSERT_NOW(a_char_set, clk, arst_n, text_valid, (text_character >= pifc_pkg::CH_ZERO && text_character <= pifc_pkg::CH_NINE) || (text_character >= pifc_pkg::CH_A && text_character <= pifc_pkg::CH_F) || (text_character == pifc_pkg::CH_SPACE) || (text_character == pifc_pkg::CH_PLUS) || (text_character == pifc_pkg::CH_MINUS) || (text_character == pifc_pkg::CH_X))
	`PIFC_ASSERT_NOW(a_x_not_last, clk, arst_n, text_valid && text_character == pifc_pkg::CH_X, !text_last_char)
endmodule

bind printf_integer_formatter_core pifc_checker u_pifc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.text_valid     (text.valid),
	.text_ready     (text.ready),
	.text_character (text.character),
	.text_last_char (text.last_char)
);
